// ----- sv/exisram_pkg.sv -----
// ----------------------------------------------------------------------------
// exisram_pkg
// Shared types, codes and constants of the serial SRAM device.
// ----------------------------------------------------------------------------
package exisram_pkg;

	// Item kinds on the bus side.
	localparam logic [1:0] KIND_DESELECT = 2'd0;
	localparam logic [1:0] KIND_IMM      = 2'd1;
	localparam logic [1:0] KIND_DMA      = 2'd2;

	// Addressing of this device.
	localparam logic [1:0] DEV_CHANNEL = 2'd0;
	localparam logic [1:0] DEV_CS      = 2'd2;

	// Store geometry and the address window that maps onto it.
	localparam int          STORE_BYTES_DEF = 64;
	localparam int          LANES           = 4;
	localparam logic [31:0] WIN_LO          = 32'h0080_0004;
	localparam int          CMD_WRITE_BIT   = 31;
	localparam logic [2:0]  MAX_IMM_LEN     = 3'd4;

	// Per-item information that travels with a pending read.
	typedef struct packed {
		logic [LANES-1:0] act;   // byte lane hits the window and is moved
		logic             fwd;   // command writes: read back the written bytes
		logic             dma;   // result goes to bits 7..0
		logic [1:0]       off;   // bank of byte lane 0
		logic [31:0]      wdata; // write bytes, lane 0 in bits 31..24
	} rd_info_t;

	// Power-up image of the store: checksum bytes and one data byte.
	function automatic logic [7:0] img_byte(input int unsigned idx);
		logic [7:0] b;
		case (idx)
			32'd1:   b = 8'h2c;
			32'd2:   b = 8'hff;
			32'd3:   b = 8'hd0;
			32'd19:  b = 8'h2c;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- sv/exisram_bank.sv -----
// ----------------------------------------------------------------------------
// exisram_bank
// One byte-wide bank of the store with a registered read port and
// per-entry valid bits; an entry never written reads its power-up image.
// ----------------------------------------------------------------------------
module exisram_bank #(
	parameter int ROWS = exisram_pkg::STORE_BYTES_DEF / exisram_pkg::LANES,
	parameter int BANK = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    we,
	input  logic                    re,
	input  logic [$clog2(ROWS)-1:0] row,
	input  logic [7:0]              wdata,
	output logic [7:0]              rdata
);
	import exisram_pkg::*;

	logic [7:0]      mem [ROWS];
	logic [ROWS-1:0] vld_q;
	logic [7:0]      rdata_q;

	// Storage array, written one byte per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[row] <= wdata;
		end
	end

	// Valid bits mark entries that hold written data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[row] <= 1'b1;
		end
	end

	// Registered read; unwritten entries return the reset image.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= vld_q[row] ? mem[row]
				: img_byte(32'({row, 2'(BANK)}));
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/exisram_ctrl.sv -----
// ----------------------------------------------------------------------------
// exisram_ctrl
// Command latch, byte cursor and address generation; drives the bank
// ports and describes each pending read.
// ----------------------------------------------------------------------------
module exisram_ctrl #(
	parameter int STORE_BYTES = exisram_pkg::STORE_BYTES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   fire,
	input  logic [1:0]                             kind,
	input  logic [1:0]                             channel,
	input  logic [1:0]                             dev_select,
	input  logic                                   is_read,
	input  logic [2:0]                             length,
	input  logic [31:0]                            write_data,
	output logic [exisram_pkg::LANES-1:0]          bank_we,
	output logic [exisram_pkg::LANES-1:0]          bank_re,
	output logic [$clog2(STORE_BYTES)-3:0]         bank_row [exisram_pkg::LANES],
	output logic [7:0]                             bank_wdata [exisram_pkg::LANES],
	output logic                                   rsp,
	output exisram_pkg::rd_info_t                  info
);
	import exisram_pkg::*;

	localparam int IDX_W = $clog2(STORE_BYTES);

	logic [31:0] cmd_q;
	logic [31:0] cur_q;
	logic        latched_q;

	logic        desel;
	logic        dev;
	logic        dma;
	logic [2:0]  len_eff;
	logic        latch;
	logic        xfer;
	logic [31:0] d;
	logic [31:0] e [LANES];
	logic [7:0]  wb [LANES];
	logic [LANES-1:0] act;
	logic [1:0]  sel [LANES];

	// Decode the item.
	always_comb begin
		desel   = (kind == KIND_DESELECT);
		dev     = (kind == KIND_IMM || kind == KIND_DMA) &&
			(channel == DEV_CHANNEL) && (dev_select == DEV_CS);
		dma     = (kind == KIND_DMA);
		if (dma) begin
			len_eff = 3'd1;
		end else if (length > MAX_IMM_LEN) begin
			len_eff = MAX_IMM_LEN;
		end else begin
			len_eff = length;
		end
		latch = dev && !latched_q && !dma && !is_read && (len_eff == MAX_IMM_LEN);
		xfer  = dev && !latch;
	end

	// Store offset of byte lane 0 and the window check of every lane.
	always_comb begin
		d = 32'({7'd0, cmd_q[30:6]}) + cur_q - WIN_LO;
		for (int i = 0; i < LANES; i++) begin
			e[i]   = d + 32'(i);
			act[i] = xfer && (3'(i) < len_eff) && (e[i][31:IDX_W] == '0);
			wb[i]  = write_data[31-8*i -: 8];
		end
	end

	// Route each lane to its bank; consecutive bytes fall in distinct banks.
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			sel[k]        = 2'(k) - d[1:0];
			bank_row[k]   = e[sel[k]][IDX_W-1:2];
			bank_wdata[k] = wb[sel[k]];
			bank_we[k]    = fire && act[sel[k]] && cmd_q[CMD_WRITE_BIT];
			bank_re[k]    = fire && act[sel[k]] && is_read;
		end
	end

	assign rsp        = fire && xfer && is_read;
	assign info.act   = act;
	assign info.fwd   = cmd_q[CMD_WRITE_BIT];
	assign info.dma   = dma;
	assign info.off   = d[1:0];
	assign info.wdata = write_data;

	// Command latch and byte cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= '0;
			cur_q     <= '0;
			latched_q <= 1'b0;
		end else if (fire) begin
			if (desel) begin
				latched_q <= 1'b0;
				cur_q     <= '0;
			end else if (latch) begin
				cmd_q     <= write_data;
				cur_q     <= '0;
				latched_q <= 1'b1;
			end else if (xfer) begin
				cur_q <= cur_q + 32'(len_eff);
			end
		end
	end

endmodule

// ----- sv/exisram_top_unused.sv -----
// ----------------------------------------------------------------------------
// exisram_lane_pack
// Builds the result word of a read from the bank outputs.
// ----------------------------------------------------------------------------
module exisram_lane_pack (
	input  exisram_pkg::rd_info_t                 info,
	input  logic [7:0]                            rdata [exisram_pkg::LANES],
	output logic [31:0]                           value
);
	import exisram_pkg::*;

	logic [7:0] b [LANES];
	logic [1:0] k [LANES];

	// A written byte reads back as written; lanes outside the window or beyond the length read zero.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			k[i] = info.off + 2'(i);
			if (!info.act[i]) begin
				b[i] = 8'h00;
			end else if (info.fwd) begin
				b[i] = info.wdata[31-8*i -: 8];
			end else begin
				b[i] = rdata[k[i]];
			end
		end
		if (info.dma) begin
			value = {24'd0, b[0]};
		end else begin
			value = {b[0], b[1], b[2], b[3]};
		end
	end

endmodule

// ----- sv/exi_serial_sram_device.sv -----
// ----------------------------------------------------------------------------
// exi_serial_sram_device
// 64-byte serial SRAM on bus channel 0, chip select 2.
// ----------------------------------------------------------------------------
// The store sits in four byte-wide banks, one per low address bit pair, so
// the up to four consecutive bytes of a transfer are read or written
// together. An item is taken every cycle as long as the result register is
// free or drains; a read result passes through the registered bank read
// and then the result register. Writes, command latches and deselects
// produce no result. The store comes out of reset holding its default
// image, with no clearing pass.
module exi_serial_sram_device #(
	parameter int STORE_BYTES = exisram_pkg::STORE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  kind,
	input  logic [1:0]  channel,
	input  logic [1:0]  dev_select,
	input  logic        is_read,
	input  logic [2:0]  length,
	input  logic [31:0] write_data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] read_data
);
	import exisram_pkg::*;

	localparam int ROWS  = STORE_BYTES / LANES;
	localparam int ROW_W = $clog2(STORE_BYTES) - 2;

	logic             fire;
	logic [LANES-1:0] bank_we;
	logic [LANES-1:0] bank_re;
	logic [ROW_W-1:0] bank_row [LANES];
	logic [7:0]       bank_wdata [LANES];
	logic [7:0]       bank_rdata [LANES];
	logic             rsp;
	rd_info_t         info;

	logic             pend_s1;
	rd_info_t         info_s1;
	logic             adv;
	logic [31:0]      value;
	logic             out_valid_q;
	logic [31:0]      read_data_q;

	// Input transfer is taken when no read is pending or the pending read can move on.
	assign adv        = pend_s1 && (!out_valid_q || result_ready);
	assign item_ready = !pend_s1 || adv;
	assign fire       = item_valid && item_ready;

	exisram_ctrl #(
		.STORE_BYTES(STORE_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.kind       (kind),
		.channel    (channel),
		.dev_select (dev_select),
		.is_read    (is_read),
		.length     (length),
		.write_data (write_data),
		.bank_we    (bank_we),
		.bank_re    (bank_re),
		.bank_row   (bank_row),
		.bank_wdata (bank_wdata),
		.rsp        (rsp),
		.info       (info)
	);

	// Four interleaved banks.
	for (genvar k = 0; k < LANES; k++) begin : g_bank
		exisram_bank #(
			.ROWS(ROWS),
			.BANK(k)
		) u_bank (
			.clk   (clk),
			.arst_n(arst_n),
			.we    (bank_we[k]),
			.re    (bank_re[k]),
			.row   (bank_row[k]),
			.wdata (bank_wdata[k]),
			.rdata (bank_rdata[k])
		);
	end

	// Pending read stage, waiting on the bank read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (fire) begin
			pend_s1 <= rsp;
		end else if (adv) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			info_s1 <= info;
		end
	end

	exisram_lane_pack u_pack (
		.info (info_s1),
		.rdata(bank_rdata),
		.value(value)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q <= value;
		end
	end

	assign result_valid = out_valid_q;
	assign read_data    = read_data_q;

endmodule
